// ===== design/positional_list_insert_delete_assert.svh =====
// assertion macros for the positional list block
// used by positional_list_insert_delete.sv; expects i_clk and i_rst_n in scope
`ifndef POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH
`define POSITIONAL_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define PL_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("positional list assertion failed");

// next-cycle implication, disabled during reset
`define PL_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("positional list assertion failed");

`endif

// ===== design/pos_list_pkg.sv =====
// shared types and constants for the positional list block
// no dependencies; imported by positional_list_insert_delete
`default_nettype none

package pos_list_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int POS_W        = 9;
    localparam int LEN_W        = 9;
    localparam int WORD_W       = 32;

    // operation codes
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_DELETE = 1'b1;

    // status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_BADPOS = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic                     kind;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic                     ok;
        logic [1:0]               status;
        logic signed [WORD_W-1:0] removed_value;
        logic [LEN_W-1:0]         length;
    } t_rsp;

endpackage

`default_nettype wire

// ===== design/positional_list_insert_delete.sv =====
// positional list with insert and delete, top level
// depends on pos_list_pkg and positional_list_insert_delete_assert.svh
// usage:
//   a request is taken at a rising edge with start high and busy low. it
//   carries kind (insert or delete), a 1-based position and a value.
//   insert needs position 1..length+1, delete needs 1..length; anything
//   else returns status bad position, an insert into a full list returns
//   status full. exactly one response per request shows on o_rsp for a
//   single cycle, flagged by o_valid; the receiver has no way to stall.
// timing:
//   a rejected request answers the cycle after it is taken and never
//   raises busy. an accepted request walks the tail of the list through
//   one memory read port and one write port, one entry per cycle, and
//   holds busy for the whole walk; the response is registered and shows
//   as busy drops, and a new request is taken only once busy is low.
// reset:
//   synchronous, active low. the length goes to zero and the sequencer to
//   idle; the list memory is not cleared, since only entries below the
//   length are ever read and each of those was written first.
`default_nettype none

`include "positional_list_insert_delete_assert.svh"

module positional_list_insert_delete
    import pos_list_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic start,
    output logic      busy,
    input  wire t_req i_req,
    output logic      o_valid,
    output t_rsp      o_rsp
);

    localparam int IW   = $clog2(CAPACITY);
    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // one-hot sequencer
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_INS  = 3'b010,
        S_DEL  = 3'b100
    } t_state;

    // list storage
    logic [WORD_W-1:0] r_mem [CAPACITY];

    t_state            r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [CW-1:0]     r_ptr, n_ptr;     // walk pointer
    logic [CW-1:0]     r_pos, n_pos;     // 0-based target index
    logic              r_wv, n_wv;       // pending shifted write
    logic [IW-1:0]     r_wa, n_wa;       // its address
    logic              r_tk, n_tk;       // read data is the removed word
    logic              r_vld, n_vld;
    t_rsp              r_rsp, n_rsp;
    logic [WORD_W-1:0] r_val;
    logic [WORD_W-1:0] r_taken;
    logic [WORD_W-1:0] r_rdata;

    // memory port controls
    logic              mem_re;
    logic [IW-1:0]     mem_ra;
    logic              mem_we;
    logic [IW-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;

    logic              accept;
    logic [CMPW-1:0]   pos_x;
    logic [CMPW-1:0]   cnt_x;
    logic              ins_pos_ok;
    logic              del_pos_ok;
    logic              full;
    logic [CW-1:0]     pos_m1;
    logic [CW-1:0]     ptr_m1;

    assign busy    = (r_state != S_IDLE);
    assign accept  = start && !busy;
    assign o_valid = r_vld;
    assign o_rsp   = r_rsp;

    // range checks in a width that holds both position and length
    assign pos_x      = CMPW'(i_req.position);
    assign cnt_x      = CMPW'(r_count);
    assign ins_pos_ok = (pos_x != '0) && (pos_x <= cnt_x + CMPW'(1));
    assign del_pos_ok = (pos_x != '0) && (pos_x <= cnt_x);
    assign full       = (r_count == CW'(CAPACITY));
    assign pos_m1     = CW'(pos_x - CMPW'(1));
    assign ptr_m1     = r_ptr - CW'(1);

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_ptr   = r_ptr;
        n_pos   = r_pos;
        n_wv    = 1'b0;
        n_wa    = r_wa;
        n_tk    = 1'b0;
        n_vld   = 1'b0;
        n_rsp   = r_rsp;
        mem_re  = 1'b0;
        mem_ra  = '0;
        // retire the word read last cycle into its shifted slot
        mem_we  = r_wv;
        mem_wa  = r_wa;
        mem_wd  = r_rdata;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    // default answer is a rejected request
                    n_rsp = '{ok: 1'b0, status: ST_BADPOS, removed_value: '0,
                              length: LEN_W'(r_count)};
                    if (i_req.kind == KIND_INSERT) begin
                        if (!ins_pos_ok) begin
                            n_vld = 1'b1;
                        end else if (full) begin
                            n_vld        = 1'b1;
                            n_rsp.status = ST_FULL;
                        end else begin
                            // walk down from the end of the list
                            n_pos   = pos_m1;
                            n_ptr   = r_count;
                            n_state = S_INS;
                        end
                    end else begin
                        if (!del_pos_ok) begin
                            n_vld = 1'b1;
                        end else begin
                            // walk up from the removed slot
                            n_pos   = pos_m1;
                            n_ptr   = pos_m1;
                            n_state = S_DEL;
                        end
                    end
                end
            end

            S_INS: begin
                if (r_ptr != r_pos) begin
                    // read entry ptr-1, write it to ptr next cycle
                    mem_re = 1'b1;
                    mem_ra = ptr_m1[IW-1:0];
                    n_ptr  = ptr_m1;
                    n_wv   = 1'b1;
                    n_wa   = r_ptr[IW-1:0];
                end else if (!r_wv) begin
                    // gap is open, drop the new word in
                    mem_we  = 1'b1;
                    mem_wa  = r_pos[IW-1:0];
                    mem_wd  = r_val;
                    n_count = r_count + CW'(1);
                    n_vld   = 1'b1;
                    n_rsp   = '{ok: 1'b1, status: ST_DONE, removed_value: '0,
                                length: LEN_W'(r_count + CW'(1))};
                    n_state = S_IDLE;
                end
            end

            S_DEL: begin
                if (r_ptr != r_count) begin
                    // read entry ptr, write it to ptr-1 next cycle;
                    // the first read is the removed word itself
                    mem_re = 1'b1;
                    mem_ra = r_ptr[IW-1:0];
                    n_ptr  = r_ptr + CW'(1);
                    n_wv   = (r_ptr != r_pos);
                    n_wa   = ptr_m1[IW-1:0];
                    n_tk   = (r_ptr == r_pos);
                end else if (!r_wv && !r_tk) begin
                    n_count = r_count - CW'(1);
                    n_vld   = 1'b1;
                    n_rsp   = '{ok: 1'b1, status: ST_DONE, removed_value: r_taken,
                                length: LEN_W'(r_count - CW'(1))};
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_wv    <= 1'b0;
            r_tk    <= 1'b0;
            r_vld   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_wv    <= n_wv;
            r_tk    <= n_tk;
            r_vld   <= n_vld;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_ptr <= n_ptr;
        r_pos <= n_pos;
        r_wa  <= n_wa;
        r_rsp <= n_rsp;
        if (accept) begin
            r_val <= i_req.value;
        end
        if (r_tk) begin
            r_taken <= r_rdata;
        end
    end

    // list memory, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_re) begin
            r_rdata <= r_mem[mem_ra];
        end
    end

    // a response never overlaps a busy period
    `PL_ASSERT_IMP(a_valid_not_busy, o_valid, !busy)
    // length stays within capacity
    `PL_ASSERT_IMP(a_count_cap, 1'b1, r_count <= CW'(CAPACITY))
    // every taken request either answers at once or starts a walk
    `PL_ASSERT_NXT(a_accept_moves, accept, o_valid || busy)
    // a finished delete shortens the list by one
    `PL_ASSERT_NXT(a_del_shrinks, (r_state == S_DEL) && (n_state == S_IDLE),
                   r_count == $past(r_count) - CW'(1))

endmodule

`default_nettype wire
